### src/kgb_pkg.sv
// shared types and constants of the neighborhood graph builder
`default_nettype none
package kgb_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int MAX_POINTS  = 64;
   localparam int PIDX_W      = 6;
   localparam int NPTS_W      = 7;
   localparam int ROW_W       = 64;
   localparam int RADIUS_W    = 18;
   localparam int LIMIT_W     = 2 * RADIUS_W;
   localparam int KCNT_W      = 6;
   localparam int DIMCFG_W    = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 18;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_TOO_MANY = 2'd2;
   localparam logic [1:0] ST_PARTIAL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE_KNN       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBOR_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS         = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_IN_USE    = 2'd3;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] coordinate;
      logic                          last;
   } req_payload_type;

   typedef struct packed {
      logic [PIDX_W-1:0] row_index;
      logic [ROW_W-1:0]  row_bits;
      logic [1:0]        status;
      logic              row_last;
   } rsp_payload_type;

endpackage
`default_nettype wire

### src/kgb_ram.sv
// generic single write, single read memory with registered read data
`default_nettype none
module kgb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### src/knn_or_radius_graph_builder.sv
// loading takes one coordinate per cycle; after the last one a repeated subtraction
// divides the coordinate count by the dimensions to count the points.
// per row i: point i is copied into a local cache, then distances run through the
// shared subtract-square-accumulate unit; knn mode then ranks each candidate.
// output: rows leave under the response handshake; one set is handled at a time.
// synchronous reset clears control state and CSRs, not datapath regs or the memories.
`default_nettype none
module knn_or_radius_graph_builder import kgb_pkg::*; #(
   parameter int MAX_DIMS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW     = COORD_WIDTH;
   localparam int DEPTH  = MAX_POINTS * MAX_DIMS;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_W  = $clog2(MAX_DIMS + 1);
   localparam int DI_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DIST_W = 2 * CW + $clog2(MAX_DIMS) + 1;

   typedef enum logic [3:0] {
      S_LOAD, S_DIV, S_CACHE, S_DIST, S_RJ, S_RCAP, S_RM, S_WROW, S_OC, S_SEND
   } state_type;

   state_type state_ff, state_in;

   logic                mode_knn_ff, mode_knn_in;
   logic [KCNT_W-1:0]   neighbor_count_ff, neighbor_count_in;
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [DIMCFG_W-1:0] dims_in_use_ff, dims_in_use_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [NPTS_W-1:0] quot_ff, quot_in;
   logic [DIM_W-1:0]  dims_ff, dims_in;
   logic [PIDX_W-1:0] last_idx_ff, last_idx_in;
   logic [PIDX_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [DIM_W-1:0]  c_ff, c_in;
   logic [ADDR_W-1:0] p_ff, p_in;
   logic [DIM_W-1:0]  d_ff, d_in;
   logic [PIDX_W-1:0] j_ff, j_in;
   logic [PIDX_W-1:0] rj_ff, rj_in;
   logic [PIDX_W-1:0] oi_ff, oi_in;
   logic              iss_ff, iss_in;
   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic [NPTS_W-1:0] rank_ff, rank_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   // datapath registers
   logic [PIDX_W-1:0]   t1_ff, t1_in, t2_ff;
   logic [DI_W-1:0]     d1_ff, d1_in;
   logic                first1_ff, first1_in, last1_ff, last1_in;
   logic                first2_ff, last2_ff;
   logic [2*CW-1:0]     sq_ff, sq_in;
   logic [DIST_W-1:0]   acc_ff, acc_in;
   logic [DIST_W-1:0]   dj_ff, dj_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ROW_W-1:0]    col_ff, col_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic signed [CW-1:0] cache_ff [MAX_DIMS];

   // memory ports
   logic              st_we;
   logic [ADDR_W-1:0] st_waddr, st_raddr;
   logic [CW-1:0]     st_rdata;
   logic              ds_we;
   logic [PIDX_W-1:0] ds_raddr;
   logic [DIST_W-1:0] ds_rdata, sum;
   logic              adj_we;
   logic [PIDX_W-1:0] adj_raddr;
   logic [ROW_W-1:0]  adj_rdata;
   logic              cache_we;
   logic [DI_W-1:0]   cache_widx;

   logic                 req_fire, stored;
   logic [DIM_W-1:0]     dims_eff;
   logic signed [CW:0]   diff;
   logic [CW-1:0]        mag;
   logic [2*CW-1:0]      mag_ext;
   logic signed [CW-1:0] xi;

   assign req_ready = (state_ff == S_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign stored    = (32'(count_ff) < 32'(DEPTH));
   assign dims_eff  = (32'(dims_in_use_ff) > 32'(MAX_DIMS)) ? DIM_W'(MAX_DIMS)
                                                             : DIM_W'(dims_in_use_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // shared subtract-square unit and accumulator
   assign xi      = cache_ff[d1_ff];
   assign diff    = $signed({xi[CW-1], xi}) - $signed({st_rdata[CW-1], st_rdata});
   assign mag     = diff[CW] ? CW'(-diff) : CW'(diff);
   assign mag_ext = {{CW{1'b0}}, mag};
   assign sq_in   = mag_ext * mag_ext;
   assign sum     = (first2_ff ? '0 : acc_ff) + DIST_W'(sq_ff);

   assign st_we    = req_fire && stored;
   assign st_waddr = ADDR_W'(count_ff);
   assign st_raddr = (state_ff == S_CACHE) ? ADDR_W'(base_ff + ADDR_W'(c_ff)) : p_ff;
   assign ds_we    = (state_ff == S_DIST) && v2_ff && last2_ff;
   assign ds_raddr = (state_ff == S_RJ) ? rj_ff : j_ff;
   assign adj_we   = (state_ff == S_WROW);
   assign adj_raddr = j_ff;
   assign cache_we   = (state_ff == S_CACHE) && (c_ff != '0);
   assign cache_widx = DI_W'(c_ff - 1'b1);

   kgb_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_store (
      .clock, .wr_en(st_we), .wr_addr(st_waddr), .wr_data(req_data.coordinate),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   kgb_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_dist (
      .clock, .wr_en(ds_we), .wr_addr(t2_ff), .wr_data(sum),
      .rd_addr(ds_raddr), .rd_data(ds_rdata)
   );

   kgb_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_adj (
      .clock, .wr_en(adj_we), .wr_addr(i_ff), .wr_data(row_ff),
      .rd_addr(adj_raddr), .rd_data(adj_rdata)
   );

   always_comb begin
      state_in          = state_ff;
      mode_knn_in       = mode_knn_ff;
      neighbor_count_in = neighbor_count_ff;
      radius_in         = radius_ff;
      dims_in_use_in    = dims_in_use_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      dims_in     = dims_ff;
      last_idx_in = last_idx_ff;
      i_in        = i_ff;
      base_in     = base_ff;
      c_in        = c_ff;
      p_in        = p_ff;
      d_in        = d_ff;
      j_in        = j_ff;
      rj_in       = rj_ff;
      oi_in       = oi_ff;
      iss_in      = iss_ff;
      v1_in       = 1'b0;
      v2_in       = 1'b0;
      rank_in     = rank_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in      = rsp_ff;
      t1_in       = j_ff;
      d1_in       = d_ff[DI_W-1:0];
      first1_in   = (d_ff == '0);
      last1_in    = (d_ff == DIM_W'(dims_ff - 1'b1));
      acc_in      = acc_ff;
      dj_in       = dj_ff;
      row_in      = row_ff;
      col_in      = col_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE_KNN:       mode_knn_in       = csr_wdata[0];
            CSR_NEIGHBOR_COUNT: neighbor_count_in = csr_wdata[KCNT_W-1:0];
            CSR_RADIUS:         radius_in         = csr_wdata[RADIUS_W-1:0];
            CSR_DIMS_IN_USE:    dims_in_use_in    = csr_wdata[DIMCFG_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (stored) begin
                  count_in = CNT_W'(count_ff + 1'b1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last) begin
                  rem_in   = stored ? CNT_W'(count_ff + 1'b1) : count_ff;
                  count_in = '0;
                  quot_in  = '0;
                  dims_in  = dims_eff;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (dims_ff == '0 || quot_ff > NPTS_W'(MAX_POINTS) ||
                rem_ff < CNT_W'(dims_ff)) begin
               ovf_in = 1'b0;
               rsp_in.row_index = '0;
               rsp_in.row_bits  = '0;
               rsp_in.row_last  = 1'b1;
               if (dims_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else if (ovf_ff || quot_ff > NPTS_W'(MAX_POINTS)) begin
                  rsp_in.status = ST_TOO_MANY;
               end else if (rem_ff != '0) begin
                  rsp_in.status = ST_PARTIAL;
               end else begin
                  rsp_in.status = ST_EMPTY;
               end
               if (dims_ff != '0 && !ovf_ff && quot_ff <= NPTS_W'(MAX_POINTS) &&
                   rem_ff == '0 && quot_ff != '0) begin
                  last_idx_in = PIDX_W'(quot_ff - 1'b1);
                  i_in     = '0;
                  base_in  = '0;
                  c_in     = '0;
                  row_in   = '0;
                  state_in = S_CACHE;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_SEND;
               end
            end else begin
               rem_in  = CNT_W'(rem_ff - CNT_W'(dims_ff));
               quot_in = NPTS_W'(quot_ff + 1'b1);
            end
         end
         S_CACHE: begin
            // point i is copied into the local cache one coordinate a cycle
            if (c_ff == dims_ff) begin
               p_in     = '0;
               d_in     = '0;
               j_in     = '0;
               iss_in   = 1'b1;
               state_in = S_DIST;
            end else begin
               c_in = DIM_W'(c_ff + 1'b1);
            end
         end
         S_DIST: begin
            if (iss_ff) begin
               v1_in = 1'b1;
               p_in  = ADDR_W'(p_ff + 1'b1);
               if (d_ff == DIM_W'(dims_ff - 1'b1)) begin
                  d_in = '0;
                  if (j_ff == last_idx_ff) begin
                     iss_in = 1'b0;
                  end else begin
                     j_in = PIDX_W'(j_ff + 1'b1);
                  end
               end else begin
                  d_in = DIM_W'(d_ff + 1'b1);
               end
            end
            v2_in = v1_ff;
            if (v2_ff) begin
               acc_in = sum;
               if (last2_ff && !mode_knn_ff) begin
                  row_in[t2_ff] = (t2_ff != i_ff) && (64'(sum) <= 64'(limit_ff));
               end
            end
            if (!iss_ff && !v1_ff && !v2_ff) begin
               rj_in    = '0;
               state_in = mode_knn_ff ? S_RJ : S_WROW;
            end
         end
         S_RJ: begin
            if (rj_ff == i_ff) begin
               if (rj_ff == last_idx_ff) begin
                  state_in = S_WROW;
               end else begin
                  rj_in = PIDX_W'(rj_ff + 1'b1);
               end
            end else begin
               state_in = S_RCAP;
            end
         end
         S_RCAP: begin
            dj_in    = ds_rdata;
            j_in     = '0;
            iss_in   = 1'b1;
            rank_in  = '0;
            state_in = S_RM;
         end
         S_RM: begin
            // count the points that rank ahead of candidate rj
            if (iss_ff) begin
               v1_in = 1'b1;
               if (j_ff == last_idx_ff) begin
                  iss_in = 1'b0;
               end else begin
                  j_in = PIDX_W'(j_ff + 1'b1);
               end
            end
            if (v1_ff && t1_ff != i_ff && t1_ff != rj_ff &&
                (ds_rdata < dj_ff || (ds_rdata == dj_ff && t1_ff < rj_ff))) begin
               rank_in = NPTS_W'(rank_ff + 1'b1);
            end
            if (!iss_ff && !v1_ff) begin
               row_in[rj_ff] = (rank_ff < {1'b0, neighbor_count_ff});
               if (rj_ff == last_idx_ff) begin
                  state_in = S_WROW;
               end else begin
                  rj_in    = PIDX_W'(rj_ff + 1'b1);
                  state_in = S_RJ;
               end
            end
         end
         S_WROW: begin
            if (i_ff == last_idx_ff) begin
               oi_in    = '0;
               j_in     = '0;
               iss_in   = 1'b1;
               col_in   = '0;
               state_in = S_OC;
            end else begin
               i_in     = PIDX_W'(i_ff + 1'b1);
               base_in  = ADDR_W'(base_ff + ADDR_W'(dims_ff));
               c_in     = '0;
               row_in   = '0;
               state_in = S_CACHE;
            end
         end
         S_OC: begin
            // own row or'd with its column makes the graph symmetric
            if (iss_ff) begin
               v1_in = 1'b1;
               if (j_ff == last_idx_ff) begin
                  iss_in = 1'b0;
               end else begin
                  j_in = PIDX_W'(j_ff + 1'b1);
               end
            end
            if (v1_ff) begin
               col_in[t1_ff] = col_ff[t1_ff] | adj_rdata[oi_ff];
               if (t1_ff == oi_ff) begin
                  col_in = col_in | adj_rdata;
               end
            end
            if (!iss_ff && !v1_ff) begin
               rsp_in.row_index = oi_ff;
               rsp_in.row_bits  = col_ff;
               rsp_in.status    = ST_OK;
               rsp_in.row_last  = (oi_ff == last_idx_ff);
               rsp_valid_in     = 1'b1;
               state_in         = S_SEND;
            end
         end
         S_SEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.row_last) begin
                  state_in = S_LOAD;
               end else begin
                  oi_in    = PIDX_W'(oi_ff + 1'b1);
                  j_in     = '0;
                  iss_in   = 1'b1;
                  col_in   = '0;
                  state_in = S_OC;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_LOAD;
         mode_knn_ff       <= 1'b0;
         neighbor_count_ff <= KCNT_W'(1);
         radius_ff         <= '0;
         dims_in_use_ff    <= DIMCFG_W'(1);
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         rem_ff      <= '0;
         quot_ff     <= '0;
         dims_ff     <= '0;
         last_idx_ff <= '0;
         i_ff        <= '0;
         base_ff     <= '0;
         c_ff        <= '0;
         p_ff        <= '0;
         d_ff        <= '0;
         j_ff        <= '0;
         rj_ff       <= '0;
         oi_ff       <= '0;
         iss_ff      <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         rank_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff      <= '0;
      end else begin
         state_ff          <= state_in;
         mode_knn_ff       <= mode_knn_in;
         neighbor_count_ff <= neighbor_count_in;
         radius_ff         <= radius_in;
         dims_in_use_ff    <= dims_in_use_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         rem_ff      <= rem_in;
         quot_ff     <= quot_in;
         dims_ff     <= dims_in;
         last_idx_ff <= last_idx_in;
         i_ff        <= i_in;
         base_ff     <= base_in;
         c_ff        <= c_in;
         p_ff        <= p_in;
         d_ff        <= d_in;
         j_ff        <= j_in;
         rj_ff       <= rj_in;
         oi_ff       <= oi_in;
         iss_ff      <= iss_in;
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
         rank_ff     <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff      <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff     <= t1_in;
      d1_ff     <= d1_in;
      first1_ff <= first1_in;
      last1_ff  <= last1_in;
      t2_ff     <= t1_ff;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      sq_ff     <= sq_in;
      acc_ff    <= acc_in;
      dj_ff     <= dj_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      limit_ff  <= LIMIT_W'(radius_ff * radius_ff);
      if (cache_we) begin
         cache_ff[cache_widx] <= st_rdata;
      end
   end

endmodule
`default_nettype wire

### src/kgb_checker.sv
// port-level checks of the graph builder, bound to the top level
`default_nettype none
module kgb_checker import kgb_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire rsp_payload_type       rsp_data
);

   // no new request while a row is waiting
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a row waits");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("row changed while stalled");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.row_last && rsp_data.row_bits == '0)
      else $error("error result malformed");

   a_no_self: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.row_bits[rsp_data.row_index])
      else $error("point connected to itself");

endmodule

bind knn_or_radius_graph_builder kgb_checker u_kgb_checker (.*);
`default_nettype wire

### tb/graph_checker.sv
// scoreboard of the graph builder: mirrors registers, predicts adjacency rows, compares
module graph_checker import kgb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire req_payload_type       req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire rsp_payload_type       rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         failures,
   output int                         rows_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_LIMIT = 16;
   localparam int STORE_SIZE = MAX_POINTS * DIM_LIMIT;

   logic                knn_mode;
   logic [KCNT_W-1:0]   k_nearest;
   logic [RADIUS_W-1:0] radius_cfg;
   logic [DIMCFG_W-1:0] dims_cfg;

   logic signed [COORD_WIDTH-1:0] points [STORE_SIZE];
   int                            loaded;
   logic                          store_full;
   rsp_payload_type               expected_rows [$];

   assign rows_pending = expected_rows.size();

   function automatic longint unsigned pair_distance(int a, int b, int dims);
      longint unsigned sum;
      longint signed   diff;
      sum = 0;
      for (int d = 0; d < dims; d++) begin
         diff = longint'(points[a*dims+d]) - longint'(points[b*dims+d]);
         sum += longint'(diff * diff);
      end
      return sum;
   endfunction

   task automatic close_set();
      int              dims, npts;
      logic [1:0]      code;
      logic [ROW_W-1:0] adj [MAX_POINTS];
      longint unsigned row_dist [MAX_POINTS];
      longint unsigned limit;
      int              rank;
      logic            link;
      rsp_payload_type row;
      dims = (dims_cfg > DIM_LIMIT) ? DIM_LIMIT : int'(dims_cfg);
      npts = (dims != 0) ? loaded / dims : 0;
      if (dims == 0) code = ST_EMPTY;
      else if (store_full || npts > MAX_POINTS) code = ST_TOO_MANY;
      else if (loaded % dims != 0) code = ST_PARTIAL;
      else code = ST_OK;
      if (code != ST_OK || npts == 0) begin
         row.row_index = '0;
         row.row_bits  = '0;
         row.status    = (code != ST_OK) ? code : ST_EMPTY;
         row.row_last  = 1'b1;
         expected_rows.push_back(row);
         return;
      end
      limit = longint'(radius_cfg) * longint'(radius_cfg);
      for (int i = 0; i < MAX_POINTS; i++) adj[i] = '0;
      for (int i = 0; i < npts; i++) begin
         for (int j = 0; j < npts; j++)
            row_dist[j] = (i == j) ? 0 : pair_distance(i, j, dims);
         for (int j = 0; j < npts; j++) begin
            if (j == i) continue;
            if (knn_mode) begin
               rank = 0;
               for (int m = 0; m < npts; m++) begin
                  if (m == i || m == j) continue;
                  if (row_dist[m] < row_dist[j] || (row_dist[m] == row_dist[j] && m < j))
                     rank++;
               end
               link = rank < int'(k_nearest);
            end else begin
               link = row_dist[j] <= limit;
            end
            if (link) begin
               adj[i][j] = 1'b1;
               adj[j][i] = 1'b1;
            end
         end
      end
      for (int i = 0; i < npts; i++) begin
         row.row_index = PIDX_W'(i);
         row.row_bits  = adj[i];
         row.status    = ST_OK;
         row.row_last  = (i == npts - 1);
         expected_rows.push_back(row);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         knn_mode   <= 1'b0;
         k_nearest  <= KCNT_W'(1);
         radius_cfg <= '0;
         dims_cfg   <= DIMCFG_W'(1);
         loaded     = 0;
         store_full = 1'b0;
         failures   = 0;
         expected_rows.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_MODE_KNN:       knn_mode   <= csr_wdata[0];
               CSR_NEIGHBOR_COUNT: k_nearest  <= csr_wdata[KCNT_W-1:0];
               CSR_RADIUS:         radius_cfg <= csr_wdata[RADIUS_W-1:0];
               CSR_DIMS_IN_USE:    dims_cfg   <= csr_wdata[DIMCFG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (loaded < STORE_SIZE) begin
               points[loaded] = req_data.coordinate;
               loaded++;
            end else begin
               store_full = 1'b1;
            end
            if (req_data.last) begin
               close_set();
               loaded     = 0;
               store_full = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rows.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected row: index %0d bits %h status %0d last %0d",
                           rsp_data.row_index, rsp_data.row_bits, rsp_data.status,
                           rsp_data.row_last);
            end else begin
               want = expected_rows.pop_front();
               if (rsp_data.row_index !== want.row_index || rsp_data.row_bits !== want.row_bits
                   || rsp_data.status !== want.status || rsp_data.row_last !== want.row_last)
               begin
                  failures++;
                  if (failures <= 10)
                     $display("row mismatch: expected %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                              want.row_index, want.row_bits, want.status, want.row_last,
                              rsp_data.row_index, rsp_data.row_bits, rsp_data.status,
                              rsp_data.row_last);
               end
            end
         end
      end
   end
endmodule

### tb/testbench.sv
// top of the graph builder testbench: clock, reset, stimulus and verdict
module testbench import kgb_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    failures;
   int                    rows_pending;
   int                    burst_left = 0;

   always #2 clock = ~clock;

   knn_or_radius_graph_builder uut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready, .rsp_data,
      .csr_write_en, .csr_index, .csr_wdata
   );

   graph_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready, .rsp_data,
      .csr_write_en, .csr_index, .csr_wdata, .failures, .rows_pending
   );

   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // receiver: changing stall pattern plus one long hold-off
   initial begin
      int taken, pattern;
      taken = 0;
      pattern = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) taken++;
         if (taken == 11 && rsp_valid) begin
            rsp_ready <= 1'b0;
            repeat (2000) @(posedge clock);
            taken++;
         end else begin
            if ($urandom_range(0, 49) == 0) pattern = $urandom_range(0, 2);
            case (pattern)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 9) < 7);
               default: rsp_ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   function automatic logic signed [COORD_WIDTH-1:0] pick_coordinate();
      case ($urandom_range(0, 3))
         0: return COORD_WIDTH'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return COORD_WIDTH'(int'($urandom_range(0, 8)) - 4);
      endcase
   endfunction

   task automatic send_request(input logic signed [COORD_WIDTH-1:0] coord, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{coordinate: coord, last: fin};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_set(input int count);
      for (int i = 0; i < count; i++) send_request(pick_coordinate(), i == count - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic configure(input int knn, input int k, input int rad, input int dims);
      csr_write_en <= 1'b1;
      csr_index <= CSR_MODE_KNN;       csr_wdata <= CSR_DATA_W'(knn); @(posedge clock);
      csr_index <= CSR_NEIGHBOR_COUNT; csr_wdata <= CSR_DATA_W'(k);   @(posedge clock);
      csr_index <= CSR_RADIUS;         csr_wdata <= CSR_DATA_W'(rad); @(posedge clock);
      csr_index <= CSR_DIMS_IN_USE;    csr_wdata <= CSR_DATA_W'(dims); @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int sent, dims, npts, count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: radius zero links only equal points
      send_request(16'sh8000, 1'b0);
      send_request(16'sh7fff, 1'b0);
      send_request(16'sh8000, 1'b0);
      send_request(16'sh0000, 1'b1);
      drain();
      configure(0, 1, 0, 0);          // zero dimensions: empty set
      send_set(2);
      drain();
      configure(0, 1, 100, 31);       // clamped to 16 dims, 17 coords is a partial point
      send_set(17);
      drain();
      configure(1, 0, 0, 2);          // knn with no neighbors
      send_set(6);
      drain();
      configure(1, 63, 262143, 2);
      send_set(8);
      send_set(4);                    // offered while the receiver holds off
      drain();
      configure(0, 5, 262143, 1);     // too many points
      send_set(65);
      drain();

      // random sets, one to three back to back per setting
      sent = 106;
      while (sent < 110) begin
         dims = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 4);
         configure($urandom_range(0, 1), $urandom_range(0, 9) == 0 ? 63 : $urandom_range(0, 5),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 262143) : $urandom_range(0, 12),
                   dims);
         repeat ($urandom_range(1, 3)) begin
            npts = $urandom_range(1, 8);
            count = npts * (dims == 0 ? 1 : (dims > 16 ? 16 : dims));
            if ($urandom_range(0, 9) == 0) count = count + 1;
            send_set(count);
            sent += count;
         end
         drain();
      end

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

### files.f
src/kgb_pkg.sv
src/kgb_ram.sv
src/knn_or_radius_graph_builder.sv
src/kgb_checker.sv
tb/graph_checker.sv
tb/testbench.sv
